// ===== design/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash multimap
// Item structs, operation codes, controller states and default sizes.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int BucketsDef   = 256;
  localparam int NodesDef     = 64;
  localparam int ValueBitsDef = 32;

  localparam logic [1:0] ModeInsert   = 2'd0;
  localparam logic [1:0] ModeFind     = 2'd1;
  localparam logic [1:0] ModeContains = 2'd2;
  localparam logic [1:0] ModeClear    = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] data_out;
    logic        last;
    logic        status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_LINK,
    ST_NODE
  } state_t;

endpackage

// ===== design/chained_hash_multimap.sv =====
// ----------------------------------------------------------------------------
// chained_hash_multimap: hash multimap with separate chaining
// Bucket heads and a bump-allocated node pool live in synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (mode, key, data_in) enter on in_valid/in_stall; result items
//   (found, data_out, last, status) leave on out_valid/out_stall from one
//   output register. Insert links a new node at the head of the bucket of
//   key mod BUCKETS; find emits every matching value, newest first, with last
//   on the final one (or one not-found item); contains emits one item; clear
//   empties the table by resetting the pool count.
//   Clear and a dropped insert (pool full) load their result in the accept
//   cycle. Other items pass HEAD (head read), LINK (head node read) and
//   NODE, where find and contains read one chain node after another. The
//   next item is taken once the controller is back in IDLE and the output
//   register can move. When BUCKETS is not a power of two, the bucket
//   index comes from a reciprocal multiply in the extra HASH state.
//   Reset clears the pool count and the controller, then wipes the head
//   memory entry by entry with the input stalled. A head entry counts only
//   if it names an allocated node filed under the same bucket, so heads left
//   over from before a clear read as empty.
//   A stalled receiver holds the output register; the walk then waits with
//   its read data held, and no new item is taken until a result can move.
// ----------------------------------------------------------------------------
module chained_hash_multimap #(
  parameter int BUCKETS    = chm_pkg::BucketsDef,
  parameter int NODES      = chm_pkg::NodesDef,
  parameter int VALUE_BITS = chm_pkg::ValueBitsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  chm_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output chm_pkg::out_item_t  out_item
);

  localparam int  BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int  PW     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int  UW     = $clog2(NODES + 1);
  localparam int  DW     = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam bit  IsPow2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  // Reciprocal for key / BUCKETS: q = (t + ((key - t) >> 1)) >> (L - 1),
  // t = high half of key * RecipMul, exact for every 32-bit key
  localparam int          RecipL    = $clog2(BUCKETS);
  localparam int          RecipSh   = (RecipL > 0) ? RecipL - 1 : 0;
  localparam logic [63:0] RecipWide =
      ((((64'd1 << RecipL) - 64'(BUCKETS)) << 32) / 64'(BUCKETS)) + 64'd1;
  localparam logic [31:0] RecipMul  = RecipWide[31:0];

  // Storage
  logic [PW-1:0] head_mem [BUCKETS];
  logic [31:0]   nkey_mem [NODES];
  logic [DW-1:0] ndata_mem[NODES];
  logic [PW:0]   nlink_mem[NODES];
  logic [BW-1:0] nbkt_mem [NODES];

  logic [PW-1:0] head_q;
  logic [31:0]   key_q;
  logic [DW-1:0] data_q;
  logic [PW:0]   link_q;
  logic [BW-1:0] bkt_q;

  // Control and item registers
  chm_pkg::state_t state, state_next;
  logic [1:0]    mode_r;
  logic [31:0]   key_r;
  logic [DW-1:0] data_r;
  logic [BW-1:0] bucket;
  logic [31:0]   mul_hi;
  logic [31:0]   quo;
  logic [1:0]    cnt;
  logic [BW-1:0] wipe_idx;
  logic [PW-1:0] cur_idx;
  logic          cur_valid;
  logic          pend_valid;
  logic [DW-1:0] pend_data;
  logic [UW-1:0] used;

  // Decoded controls
  logic               can_emit;
  logic               accept;
  logic               emit;
  chm_pkg::out_item_t emit_item;
  logic               head_rd;
  logic               node_rd;
  logic [PW-1:0]      node_addr;
  logic               ins_we;
  logic               wipe;
  logic               clr;
  logic               advance;
  logic               pend_load;
  logic               node_ok;
  logic               node_hit;
  logic [63:0]        mul_full;

  assign can_emit = !out_valid || !out_stall;
  assign in_stall = !((state == chm_pkg::ST_IDLE) && can_emit);
  assign accept   = in_valid && !in_stall;

  assign mul_full = {32'd0, key_r} * {32'd0, RecipMul};

  // A node counts only if allocated and filed under this bucket
  assign node_ok  = cur_valid && (UW'(cur_idx) < used) && (bkt_q == bucket);
  assign node_hit = node_ok && (key_q == key_r);

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_item  = '{found: 1'b0, data_out: 32'd0, last: 1'b1, status: 1'b0};
    head_rd    = 1'b0;
    node_rd    = 1'b0;
    node_addr  = head_q;
    ins_we     = 1'b0;
    wipe       = 1'b0;
    clr        = 1'b0;
    advance    = 1'b0;
    pend_load  = 1'b0;
    case (state)
      chm_pkg::ST_WIPE: begin
        wipe = 1'b1;
        if (wipe_idx == BW'(BUCKETS - 1)) state_next = chm_pkg::ST_IDLE;
      end
      chm_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_item.mode == chm_pkg::ModeClear) begin
            clr  = 1'b1;
            emit = 1'b1;
          end else if (in_item.mode == chm_pkg::ModeInsert &&
                       used == UW'(NODES)) begin
            // Pool full: drop the insert and flag it
            emit             = 1'b1;
            emit_item.status = 1'b1;
          end else begin
            state_next = IsPow2 ? chm_pkg::ST_HEAD : chm_pkg::ST_HASH;
          end
        end
      end
      chm_pkg::ST_HASH: begin
        if (cnt == 2'd2) state_next = chm_pkg::ST_HEAD;
      end
      chm_pkg::ST_HEAD: begin
        head_rd    = 1'b1;
        state_next = chm_pkg::ST_LINK;
      end
      chm_pkg::ST_LINK: begin
        node_rd    = 1'b1;
        node_addr  = head_q;
        advance    = 1'b1;
        state_next = chm_pkg::ST_NODE;
      end
      chm_pkg::ST_NODE: begin
        node_addr = link_q[PW-1:0];
        if (mode_r == chm_pkg::ModeInsert) begin
          if (can_emit) begin
            ins_we     = 1'b1;
            emit       = 1'b1;
            state_next = chm_pkg::ST_IDLE;
          end
        end else if (!node_ok) begin
          // End of chain: flush the held match as last, or report a miss
          if (can_emit) begin
            emit = 1'b1;
            if (mode_r == chm_pkg::ModeFind && pend_valid) begin
              emit_item.found    = 1'b1;
              emit_item.data_out = 32'(pend_data);
            end
            state_next = chm_pkg::ST_IDLE;
          end
        end else if (node_hit && mode_r == chm_pkg::ModeContains) begin
          if (can_emit) begin
            emit            = 1'b1;
            emit_item.found = 1'b1;
            state_next      = chm_pkg::ST_IDLE;
          end
        end else if (node_hit) begin
          // Hold each match until the next one shows it is not the last
          if (!pend_valid || can_emit) begin
            emit               = pend_valid;
            emit_item.found    = 1'b1;
            emit_item.data_out = 32'(pend_data);
            emit_item.last     = 1'b0;
            pend_load          = 1'b1;
            node_rd            = 1'b1;
            advance            = 1'b1;
          end
        end else begin
          node_rd = 1'b1;
          advance = 1'b1;
        end
      end
      default: state_next = chm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= chm_pkg::ST_WIPE;
      used       <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      cur_valid  <= 1'b0;
      cnt        <= '0;
      wipe_idx   <= '0;
    end else begin
      state <= state_next;
      if (emit)               out_valid <= 1'b1;
      else if (!out_stall)    out_valid <= 1'b0;
      if (clr)                used <= '0;
      else if (ins_we)        used <= used + UW'(1);
      if (accept)             pend_valid <= 1'b0;
      else if (pend_load)     pend_valid <= 1'b1;
      if (advance) begin
        cur_valid <= (state == chm_pkg::ST_LINK) ? 1'b1 : link_q[PW];
      end
      if (accept)                         cnt <= '0;
      else if (state == chm_pkg::ST_HASH) cnt <= cnt + 2'd1;
      if (wipe)                           wipe_idx <= wipe_idx + BW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (emit) out_item <= emit_item;
    if (accept) begin
      mode_r <= in_item.mode;
      key_r  <= in_item.key;
      data_r <= DW'(in_item.data_in);
      if (IsPow2) bucket <= BW'(in_item.key & 32'(BUCKETS - 1));
    end else if (state == chm_pkg::ST_HASH) begin
      // Quotient in two steps, then the remainder from it
      if (cnt == 2'd0) mul_hi <= mul_full[63:32];
      if (cnt == 2'd1) quo    <= (mul_hi + ((key_r - mul_hi) >> 1)) >> RecipSh;
      if (cnt == 2'd2) bucket <= BW'(key_r - quo * 32'(BUCKETS));
    end
    if (advance)   cur_idx   <= node_addr;
    if (pend_load) pend_data <= data_q;
  end

  // Bucket head memory
  always_ff @(posedge clk) begin
    if (ins_we)    head_mem[bucket]   <= used[PW-1:0];
    else if (wipe) head_mem[wipe_idx] <= '0;
    if (head_rd) head_q <= head_mem[bucket];
  end

  // Node memories
  always_ff @(posedge clk) begin
    if (ins_we) begin
      nkey_mem[used[PW-1:0]]  <= key_r;
      ndata_mem[used[PW-1:0]] <= data_r;
      nlink_mem[used[PW-1:0]] <= {node_ok, cur_idx};
      nbkt_mem[used[PW-1:0]]  <= bucket;
    end
    if (node_rd) begin
      key_q  <= nkey_mem[node_addr];
      data_q <= ndata_mem[node_addr];
      link_q <= nlink_mem[node_addr];
      bkt_q  <= nbkt_mem[node_addr];
    end
  end

endmodule
